/* hdl/mbq_pkg.sv */
// Shared types and constants for the multichannel biquad filter.
// Beat payloads, coefficient set, per-channel history word, register codes.
// No dependencies.
package mbq_pkg;

  // Fixed field widths and number formats
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_BITS      = 24;
  localparam int COEF_FRAC_BITS = 20;
  localparam int CHAN_BITS      = 4;
  localparam int CHANNELS_DEF   = 16;
  localparam int NUM_COEFS      = 5;
  localparam int CFG_IDX_BITS   = 3;
  localparam int WARMUP_BITS    = 3;
  localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS       = PROD_BITS + 3;   // five products plus rounding bias

  // Depth of the queue between front and back
  localparam int QDEPTH = 2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;

  localparam logic [WARMUP_BITS-1:0] WARMUP_DONE = WARMUP_BITS'(4);
  localparam coef_t COEF_ONE = coef_t'(64'd1 << COEF_FRAC_BITS);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } cfg_reg_e;

  // Input beat
  typedef struct packed {
    logic [CHAN_BITS-1:0] channel;
    sample_t              sample;
  } in_t;

  // Output beat
  typedef struct packed {
    logic [CHAN_BITS-1:0] out_channel;
    sample_t              filtered;
    logic                 warming_up;
  } out_t;

  // Queue entry: input beat plus its classification
  typedef struct packed {
    in_t  item;
    logic in_range;
  } qent_t;

  // Head of queue as seen by the back end
  typedef struct packed {
    logic  valid;
    qent_t ent;
  } qbeat_t;

  // Coefficient set
  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } coefs_t;

  // Per-channel history word held in RAM
  typedef struct packed {
    logic [WARMUP_BITS-1:0] count;
    sample_t                y2;
    sample_t                y1;
    sample_t                x2;
    sample_t                x1;
  } hist_t;

  localparam int HIST_BITS = $bits(hist_t);

endpackage

/* hdl/mbq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Used for the per-channel filter history. No dependencies.
module mbq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/mbq_front.sv */
// Front end: accepts input beats, tags channels that are out of range,
// and holds them in a short queue for the back end. Depends on mbq_pkg.
module mbq_front #(
  parameter int CHANNELS = mbq_pkg::CHANNELS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  mbq_pkg::in_t    in_data_i,
  output mbq_pkg::qbeat_t head_o,
  input  logic            pop_i
);
  import mbq_pkg::*;

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  qent_t            fifo_q [QDEPTH];
  logic [QAW-1:0]   wptr_q, wptr_d;
  logic [QAW-1:0]   rptr_q, rptr_d;
  logic [QCW-1:0]   cnt_q, cnt_d;
  logic             push;
  qent_t            ent;

  // Classify the incoming beat
  always_comb begin
    ent.item     = in_data_i;
    ent.in_range = (32'(in_data_i.channel) < CHANNELS);
  end

  assign in_stall_o = (cnt_q == QCW'(QDEPTH));
  assign push       = in_valid_i && !in_stall_o;

  // Pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (push) begin
      wptr_d = (wptr_q == QAW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QAW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    cnt_d = cnt_q + QCW'(push) - QCW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= ent;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.ent   = fifo_q[rptr_q];

endmodule

/* hdl/mbq_back.sv */
// Back end: issues queued beats against the history RAM, runs the
// multiply / add / round / saturate pipeline and writes history back.
// Depends on mbq_pkg and mbq_ram.
module mbq_back #(
  parameter int CHANNELS = mbq_pkg::CHANNELS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mbq_pkg::qbeat_t head_i,
  output logic            pop_o,
  input  mbq_pkg::coefs_t coefs_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output mbq_pkg::out_t   out_data_o
);
  import mbq_pkg::*;

  localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int VDEPTH = 2 ** AW;

  localparam acc_t    ROUND_BIAS = acc_t'(64'd1 << (COEF_FRAC_BITS - 1));
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Warm-up slots in order of arrival
  localparam logic [WARMUP_BITS-1:0] SLOT_X1 = WARMUP_BITS'(0);
  localparam logic [WARMUP_BITS-1:0] SLOT_X2 = WARMUP_BITS'(1);
  localparam logic [WARMUP_BITS-1:0] SLOT_Y1 = WARMUP_BITS'(2);

  // Pipeline registers
  logic        s1_vld_q, s2_vld_q, s3_vld_q, out_vld_q;
  qent_t       s1_ent_q, s2_ent_q, s3_ent_q;
  logic        s2_warm_q, s3_warm_q;
  logic        s2_warm_d;
  hist_t       s2_hist_q, s3_hist_q;
  hist_t       s2_hist_d;
  prod_t       s2_prod_q [NUM_COEFS];
  prod_t       s2_prod_d [NUM_COEFS];
  acc_t        s3_sa_q, s3_sb_q, s3_sc_q;
  acc_t        s3_sa_d, s3_sb_d, s3_sc_d;
  out_t        out_q, out_d;
  logic [VDEPTH-1:0] vld_q;

  logic        en;
  logic        hazard;
  logic        issue;
  logic        ram_re, ram_we;
  logic [AW-1:0] raddr, waddr, s1_addr;
  logic [HIST_BITS-1:0] ram_rdata;
  hist_t       wb_hist;
  acc_t        acc, shifted;
  logic        ovf;
  sample_t     y;

  // Pipeline advances unless the output beat is held
  assign en = !out_vld_q || !out_stall_i;

  // Same-channel beat still in flight: wait for its write-back
  assign hazard = head_i.ent.in_range && (
      (s1_vld_q && s1_ent_q.item.channel == head_i.ent.item.channel) ||
      (s2_vld_q && s2_ent_q.item.channel == head_i.ent.item.channel) ||
      (s3_vld_q && s3_ent_q.item.channel == head_i.ent.item.channel));

  assign issue  = head_i.valid && en && !hazard;
  assign pop_o  = issue;

  assign raddr  = AW'(head_i.ent.item.channel);
  assign ram_re = issue && head_i.ent.in_range;
  assign waddr  = AW'(s3_ent_q.item.channel);
  assign ram_we = en && s3_vld_q && s3_ent_q.in_range;
  assign s1_addr = AW'(s1_ent_q.item.channel);

  mbq_ram #(
    .WIDTH (HIST_BITS),
    .DEPTH (CHANNELS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wb_hist),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // Stage 1: history arrives, unwritten channels count as fresh; five products
  always_comb begin
    s2_hist_d = hist_t'(ram_rdata);
    if (!vld_q[s1_addr]) begin
      s2_hist_d.count = '0;
    end
    s2_warm_d = (s2_hist_d.count < WARMUP_DONE);
    s2_prod_d[0] = $signed(coefs_i.b0) * $signed(s1_ent_q.item.sample);
    s2_prod_d[1] = $signed(coefs_i.b1) * $signed(s2_hist_d.x1);
    s2_prod_d[2] = $signed(coefs_i.b2) * $signed(s2_hist_d.x2);
    s2_prod_d[3] = $signed(coefs_i.a1) * $signed(s2_hist_d.y1);
    s2_prod_d[4] = $signed(coefs_i.a2) * $signed(s2_hist_d.y2);
  end

  // Stage 2: pairwise sums, feedback terms subtracted, bias folded in
  always_comb begin
    s3_sa_d = acc_t'(s2_prod_q[0]) + acc_t'(s2_prod_q[1]);
    s3_sb_d = acc_t'(s2_prod_q[2]) - acc_t'(s2_prod_q[3]);
    s3_sc_d = ROUND_BIAS - acc_t'(s2_prod_q[4]);
  end

  // Stage 3: final sum, scale, saturate, build output and history word
  always_comb begin
    acc     = s3_sa_q + s3_sb_q + s3_sc_q;
    shifted = acc >>> COEF_FRAC_BITS;
    ovf     = (shifted[ACC_BITS-1:SAMPLE_BITS-1] !=
               {(ACC_BITS-SAMPLE_BITS+1){shifted[ACC_BITS-1]}});
    if (!ovf) begin
      y = shifted[SAMPLE_BITS-1:0];
    end else if (shifted[ACC_BITS-1]) begin
      y = SAMPLE_MIN;
    end else begin
      y = SAMPLE_MAX;
    end

    wb_hist               = s3_hist_q;
    out_d.out_channel     = s3_ent_q.item.channel;
    out_d.filtered        = s3_ent_q.item.sample;
    out_d.warming_up      = 1'b0;
    if (s3_ent_q.in_range) begin
      if (s3_warm_q) begin
        out_d.warming_up = 1'b1;
        wb_hist.count    = s3_hist_q.count + 1'b1;
        case (s3_hist_q.count)
          SLOT_X1: wb_hist.x1 = s3_ent_q.item.sample;
          SLOT_X2: wb_hist.x2 = s3_ent_q.item.sample;
          SLOT_Y1: wb_hist.y1 = s3_ent_q.item.sample;
          default: wb_hist.y2 = s3_ent_q.item.sample;
        endcase
      end else begin
        out_d.filtered = y;
        wb_hist.x2     = s3_hist_q.x1;
        wb_hist.x1     = s3_ent_q.item.sample;
        wb_hist.y2     = s3_hist_q.y1;
        wb_hist.y1     = y;
      end
    end
  end

  // Stage valids and per-channel written flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      vld_q     <= '0;
    end else begin
      if (en) begin
        s1_vld_q  <= issue;
        s2_vld_q  <= s1_vld_q;
        s3_vld_q  <= s2_vld_q;
        out_vld_q <= s3_vld_q;
      end
      if (ram_we) begin
        vld_q[waddr] <= 1'b1;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ent_q  <= head_i.ent;
      s2_ent_q  <= s1_ent_q;
      s2_warm_q <= s2_warm_d;
      s2_hist_q <= s2_hist_d;
      for (int i = 0; i < NUM_COEFS; i++) begin
        s2_prod_q[i] <= s2_prod_d[i];
      end
      s3_ent_q  <= s2_ent_q;
      s3_warm_q <= s2_warm_q;
      s3_hist_q <= s2_hist_q;
      s3_sa_q   <= s3_sa_d;
      s3_sb_q   <= s3_sb_d;
      s3_sc_q   <= s3_sc_d;
      out_q     <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

/* hdl/multichannel_biquad_filter.sv */
// Multichannel direct-form-1 biquad: coefficient registers, front-end queue
// and back-end pipeline. Depends on mbq_pkg, mbq_front, mbq_back.
//
//   port group   dir   handshake                 beat
//   in_*         in    in_valid_i / in_stall_o   mbq_pkg::in_t (channel, sample)
//   out_*        out   out_valid_o / out_stall_i mbq_pkg::out_t (channel, result, warm)
//   cfg_*        in    cfg_valid_i / cfg_ready_o register index, 24-bit coefficient
//
// One beat per cycle while successive beats hit different channels and the
// output is not stalled. A beat whose channel is still in the pipeline waits for
// its history write-back, which follows the RAM read, multiply and add steps.
// From input accept a beat passes the queue, the back-end pipeline stages and
// the output register. Reset clears per-channel written flags at once (no
// clearing pass) and loads identity coefficients. An output stall freezes the
// pipeline; the queue of two keeps accepting until full.
module multichannel_biquad_filter #(
  parameter int CHANNELS = mbq_pkg::CHANNELS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  mbq_pkg::in_t                       in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output mbq_pkg::out_t                      out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mbq_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [mbq_pkg::COEF_BITS-1:0]      cfg_data_i
);
  import mbq_pkg::*;

  localparam int MAX_INFLIGHT = QDEPTH + 4;
  localparam int INF_W        = $clog2(MAX_INFLIGHT + 1);

  coefs_t coefs_q, coefs_d;
  qbeat_t q_head;
  logic   q_pop;
  logic   in_acc, out_acc;
  logic [INF_W-1:0] inflight_q;

  // Coefficient registers, writes beyond the list are dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    coefs_d = coefs_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_B0:  coefs_d.b0 = coef_t'(cfg_data_i);
        REG_B1:  coefs_d.b1 = coef_t'(cfg_data_i);
        REG_B2:  coefs_d.b2 = coef_t'(cfg_data_i);
        REG_A1:  coefs_d.a1 = coef_t'(cfg_data_i);
        REG_A2:  coefs_d.a2 = coef_t'(cfg_data_i);
        default: coefs_d = coefs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coefs_q.b0 <= COEF_ONE;
      coefs_q.b1 <= '0;
      coefs_q.b2 <= '0;
      coefs_q.a1 <= '0;
      coefs_q.a2 <= '0;
    end else begin
      coefs_q <= coefs_d;
    end
  end

  mbq_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .head_o     (q_head),
    .pop_i      (q_pop)
  );

  mbq_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .coefs_i     (coefs_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Beats accepted but not yet delivered
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + INF_W'(in_acc) - INF_W'(out_acc);
    end
  end

  // Checks
  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= INF_W'(MAX_INFLIGHT))
    else $error("more beats in flight than queue and pipeline hold");

  a_out_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != '0)
    else $error("output beat with no accepted input beat behind it");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_head.valid)
    else $error("back end popped an empty queue");

endmodule
